[rtl/core/fcce_pkg.sv]
package fcce_pkg;

	// Width of the configuration register index.
	localparam int CFG_IDX_W = 3;

	// Result status codes.
	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_INVALID = 2'd1;
	localparam status_t ST_RANGE   = 2'd2;
	localparam status_t ST_FULL    = 2'd3;

	// Table entry formats.
	localparam logic [1:0] FT_FAT12 = 2'd0;
	localparam logic [1:0] FT_FAT16 = 2'd1;
	localparam logic [1:0] FT_FAT32 = 2'd2;
	localparam logic [1:0] FT_NONE  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FAT_TYPE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RES_LOW      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RES_HIGH     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_IN_USE = 3'd4;

	// Configuration reset values.
	localparam logic [31:0] RST_RES_LOW      = 32'd1;
	localparam logic [31:0] RST_RES_HIGH     = 32'd4080;
	localparam logic [31:0] RST_END_MARKER   = 32'd4095;
	localparam logic [16:0] RST_BYTES_IN_USE = 17'h10000;

	// Action codes.
	typedef enum logic [3:0] {
		ACT_LOAD_BYTE   = 4'd0,
		ACT_READ_BYTE   = 4'd1,
		ACT_GET_LINK    = 4'd2,
		ACT_SET_LINK    = 4'd3,
		ACT_SET_LAST    = 4'd4,
		ACT_NTH         = 4'd5,
		ACT_ALLOC_FIRST = 4'd6,
		ACT_APPEND      = 4'd7,
		ACT_TRUNCATE    = 4'd8
	} action_t;

	// Datapath selectors.
	typedef enum logic [2:0] {ENT_HOLD, ENT_IN, ENT_LINK, ENT_SCAN, ENT_TAIL} ent_sel_t;
	typedef enum logic [1:0] {SCAN_HOLD, SCAN_FIRST, SCAN_NEXT, SCAN_AFTER_ENT} scan_sel_t;
	typedef enum logic [1:0] {RES_HOLD, RES_IN, RES_LINK, RES_SCAN} res_sel_t;
	typedef enum logic [1:0] {WV_LINKV, WV_END, WV_ZERO, WV_SCAN} wval_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      capture;
		logic      init;
		ent_sel_t  ent_sel;
		scan_sel_t scan_sel;
		res_sel_t  res_sel;
		logic      tail_load;
		logic      st_we;
		status_t   st_val;
		logic      bi_clr;
		logic      mem_re;
		logic      mem_we;
		logic      byte_mode;
		wval_sel_t wval_sel;
		logic      cnt_inc;
		logic      rb_load;
		logic      out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [3:0] act;
		logic       bad_type;
		logic       in_valid;
		status_t    loc_st;
		logic       link_valid;
		logic       link_zero;
		logic       bi_last;
		logic       byte_ok;
		logic       first_ok;
		logic       scan_last;
		logic       scan_is_tail;
		logic       walk_more;
		logic       cnt_at_bound;
		logic       steps_over;
	} sts_t;

endpackage

[rtl/core/fcce_if.sv]
// Request channel carrying one action.
interface fcce_item_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic [31:0] cluster;
	logic [31:0] link_value;
	logic [31:0] step_count;
	logic [15:0] byte_address;
	logic [7:0]  byte_value;
	modport source(output valid, action, cluster, link_value, step_count, byte_address,
		byte_value, input ready);
	modport sink(input valid, action, cluster, link_value, step_count, byte_address,
		byte_value, output ready);
endinterface

// Result channel carrying one answer per request.
interface fcce_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] result_cluster;
	logic [31:0] chain_tail;
	logic [7:0]  read_byte_value;
	modport source(output valid, status, result_cluster, chain_tail, read_byte_value,
		input ready);
	modport sink(input valid, status, result_cluster, chain_tail, read_byte_value,
		output ready);
endinterface

// Configuration write channel.
interface fcce_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[rtl/core/fcce_dp.sv]
module fcce_dp #(
	parameter int FAT_BYTES = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fcce_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [31:0]                      cfg_data,
	input  logic [3:0]                       action,
	input  logic [31:0]                      cluster,
	input  logic [31:0]                      link_value,
	input  logic [31:0]                      step_count,
	input  logic [15:0]                      byte_address,
	input  logic [7:0]                       byte_value,
	input  fcce_pkg::cmd_t                   cmd,
	output fcce_pkg::sts_t                   sts,
	output fcce_pkg::status_t                status,
	output logic [31:0]                      result_cluster,
	output logic [31:0]                      chain_tail,
	output logic [7:0]                       read_byte_value
);
	import fcce_pkg::*;

	localparam int AW = $clog2(FAT_BYTES);
	localparam logic [34:0] FatBytesW = 35'(FAT_BYTES);

	logic [1:0]  ftype_q;
	logic [31:0] rlow_q, rhigh_q, endm_q;
	logic [16:0] fbiu_q;

	logic [3:0]  act_q;
	logic [31:0] clin_q, linkv_q, steps_q;
	logic [15:0] addr_q;
	logic [7:0]  bval_q;

	logic [31:0] ent_q, scan_q, tail_q, res_q, cnt_q, raw_q;
	status_t     st_q;
	logic [7:0]  rb_q, rdata_q;
	logic [1:0]  bi_q, rdi_s1;
	logic        rdv_s1;

	status_t     out_st_q;
	logic [31:0] out_res_q, out_tail_q;
	logic [7:0]  out_rb_q;

	logic [7:0]  mem [FAT_BYTES];

	logic [34:0] usable, ent_end;
	logic [33:0] pos;
	logic [1:0]  len_last;
	logic        bad_type, ent_ok;
	status_t     loc_st;
	logic [31:0] link, wval, newraw, span, bound;
	logic [32:0] first33, scan_inc, ent_inc;
	logic [31:0] scan_next, ent_next;
	logic        scan_last, ent_last;
	logic [AW-1:0] maddr;
	logic [7:0]  wbyte;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ftype_q <= FT_FAT12;
			rlow_q  <= RST_RES_LOW;
			rhigh_q <= RST_RES_HIGH;
			endm_q  <= RST_END_MARKER;
			fbiu_q  <= RST_BYTES_IN_USE;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FAT_TYPE:     ftype_q <= cfg_data[1:0];
				REG_RES_LOW:      rlow_q  <= cfg_data;
				REG_RES_HIGH:     rhigh_q <= cfg_data;
				REG_END_MARKER:   endm_q  <= cfg_data;
				REG_BYTES_IN_USE: fbiu_q  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// Usable table size and entry location.
	assign usable   = (35'(fbiu_q) < FatBytesW) ? 35'(fbiu_q) : FatBytesW;
	assign bad_type = (ftype_q == FT_NONE);
	assign ent_ok   = (ent_q > rlow_q) && (ent_q < rhigh_q);
	assign len_last = (ftype_q == FT_FAT32) ? 2'd3 : 2'd1;

	always_comb begin
		case (ftype_q)
			FT_FAT12: pos = 34'(ent_q) + 34'(ent_q[31:1]);
			FT_FAT16: pos = {1'b0, ent_q, 1'b0};
			default:  pos = {ent_q, 2'b00};
		endcase
	end

	assign ent_end = 35'(pos) + 35'(len_last) + 35'd1;

	always_comb begin
		if (bad_type || !ent_ok) begin
			loc_st = ST_INVALID;
		end else if (ent_end > usable) begin
			loc_st = ST_RANGE;
		end else begin
			loc_st = ST_OK;
		end
	end

	// Link decode from the raw entry bytes.
	always_comb begin
		case (ftype_q)
			FT_FAT12: link = ent_q[0] ? {20'd0, raw_q[15:4]} : {20'd0, raw_q[11:0]};
			FT_FAT16: link = {16'd0, raw_q[15:0]};
			default:  link = raw_q;
		endcase
	end

	// Value to write and its merge into the raw entry.
	always_comb begin
		case (cmd.wval_sel)
			WV_LINKV: wval = linkv_q;
			WV_END:   wval = endm_q;
			WV_SCAN:  wval = scan_q;
			default:  wval = '0;
		endcase
	end

	always_comb begin
		case (ftype_q)
			FT_FAT12: begin
				if (ent_q[0]) begin
					newraw = {raw_q[31:16], wval[11:4], wval[3:0], raw_q[3:0]};
				end else begin
					newraw = {raw_q[31:16], raw_q[15:12], wval[11:8], wval[7:0]};
				end
			end
			FT_FAT16: newraw = {raw_q[31:16], wval[15:0]};
			default:  newraw = wval;
		endcase
	end

	// Search cursor stepping with wrap to the first valid cluster.
	assign first33   = {1'b0, rlow_q} + 33'd1;
	assign scan_inc  = {1'b0, scan_q} + 33'd1;
	assign ent_inc   = {1'b0, ent_q} + 33'd1;
	assign scan_last = scan_inc >= {1'b0, rhigh_q};
	assign ent_last  = ent_inc >= {1'b0, rhigh_q};
	assign scan_next = scan_last ? first33[31:0] : scan_inc[31:0];
	assign ent_next  = ent_last ? first33[31:0] : ent_inc[31:0];

	// Walk bound: valid cluster count, capped by the usable size.
	assign span  = ({1'b0, rhigh_q} > first33) ? (rhigh_q - rlow_q - 32'd1) : '0;
	assign bound = (35'(span) < usable) ? span : usable[31:0];

	// Memory address and write byte.
	assign maddr = cmd.byte_mode ? AW'(addr_q) : (pos[AW-1:0] + AW'(bi_q));
	assign wbyte = cmd.byte_mode ? bval_q : newraw[{bi_q, 3'b000} +: 8];

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[maddr] <= wbyte;
		end
		if (cmd.mem_re) begin
			rdata_q <= mem[maddr];
		end
	end

	// Byte counter and read tag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bi_q   <= '0;
			rdi_s1 <= '0;
			rdv_s1 <= 1'b0;
		end else begin
			rdv_s1 <= cmd.mem_re && !cmd.byte_mode;
			rdi_s1 <= bi_q;
			if (cmd.bi_clr) begin
				bi_q <= '0;
			end else if ((cmd.mem_re || cmd.mem_we) && !cmd.byte_mode) begin
				bi_q <= bi_q + 2'd1;
			end
		end
	end

	// Request fields and working registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= action;
			clin_q  <= cluster;
			linkv_q <= link_value;
			steps_q <= step_count;
			addr_q  <= byte_address;
			bval_q  <= byte_value;
		end
		if (cmd.st_we) begin
			st_q <= cmd.st_val;
		end else if (cmd.init) begin
			st_q <= ST_OK;
		end
		case (cmd.res_sel)
			RES_IN:   res_q <= clin_q;
			RES_LINK: res_q <= link;
			RES_SCAN: res_q <= scan_q;
			default: begin
				if (cmd.init) begin
					res_q <= '0;
				end
			end
		endcase
		if (cmd.tail_load) begin
			tail_q <= ent_q;
		end else if (cmd.init) begin
			tail_q <= '0;
		end
		if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 32'd1;
		end else if (cmd.init) begin
			cnt_q <= '0;
		end
		if (cmd.rb_load) begin
			rb_q <= rdata_q;
		end else if (cmd.init) begin
			rb_q <= '0;
		end
		case (cmd.ent_sel)
			ENT_IN:   ent_q <= clin_q;
			ENT_LINK: ent_q <= link;
			ENT_SCAN: ent_q <= scan_q;
			ENT_TAIL: ent_q <= tail_q;
			default: ;
		endcase
		case (cmd.scan_sel)
			SCAN_FIRST:     scan_q <= first33[31:0];
			SCAN_NEXT:      scan_q <= scan_next;
			SCAN_AFTER_ENT: scan_q <= ent_next;
			default: ;
		endcase
		if (rdv_s1) begin
			raw_q[{rdi_s1, 3'b000} +: 8] <= rdata_q;
		end
		if (cmd.out_load) begin
			out_st_q   <= st_q;
			out_res_q  <= res_q;
			out_tail_q <= tail_q;
			out_rb_q   <= rb_q;
		end
	end

	// Status towards the controller.
	always_comb begin
		sts.act          = act_q;
		sts.bad_type     = bad_type;
		sts.in_valid     = (clin_q > rlow_q) && (clin_q < rhigh_q);
		sts.loc_st       = loc_st;
		sts.link_valid   = (link > rlow_q) && (link < rhigh_q);
		sts.link_zero    = (link == '0);
		sts.bi_last      = (bi_q == len_last);
		sts.byte_ok      = 35'(addr_q) < usable;
		sts.first_ok     = first33 < {1'b0, rhigh_q};
		sts.scan_last    = scan_last;
		sts.scan_is_tail = (scan_q == tail_q);
		sts.walk_more    = (cnt_q < steps_q) && (cnt_q < bound);
		sts.cnt_at_bound = (cnt_q >= bound);
		sts.steps_over   = (steps_q > bound);
	end

	assign status          = out_st_q;
	assign result_cluster  = out_res_q;
	assign chain_tail      = out_tail_q;
	assign read_byte_value = out_rb_q;

endmodule

[rtl/core/fcce_ctrl.sv]
module fcce_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  fcce_pkg::sts_t sts,
	output fcce_pkg::cmd_t cmd
);
	import fcce_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_BYTE_WAIT, S_LOC, S_RD, S_RDW, S_USE, S_WR,
		S_NTH_CHK, S_PROBE, S_SCHK, S_DONE
	} state_t;

	typedef enum logic [1:0] {PH_WALK, PH_SEARCH, PH_TAIL} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   out_valid_q, out_valid_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.init = 1'b1;
				state_d  = S_DONE;
				case (sts.act)
					ACT_LOAD_BYTE: begin
						if (sts.byte_ok) begin
							cmd.mem_we    = 1'b1;
							cmd.byte_mode = 1'b1;
						end else begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_RANGE;
						end
					end
					ACT_READ_BYTE: begin
						if (sts.byte_ok) begin
							cmd.mem_re    = 1'b1;
							cmd.byte_mode = 1'b1;
							state_d       = S_BYTE_WAIT;
						end else begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_RANGE;
						end
					end
					ACT_GET_LINK, ACT_SET_LINK, ACT_SET_LAST: begin
						cmd.ent_sel = ENT_IN;
						state_d     = S_LOC;
					end
					ACT_NTH: begin
						cmd.ent_sel = ENT_IN;
						cmd.res_sel = RES_IN;
						if (sts.bad_type || !sts.in_valid) begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_INVALID;
						end else begin
							state_d = S_NTH_CHK;
						end
					end
					ACT_ALLOC_FIRST: begin
						cmd.st_we = 1'b1;
						if (sts.bad_type) begin
							cmd.st_val = ST_INVALID;
						end else begin
							cmd.st_val   = ST_FULL;
							cmd.scan_sel = SCAN_FIRST;
							if (sts.first_ok) begin
								state_d = S_PROBE;
							end
						end
					end
					ACT_APPEND: begin
						if (sts.bad_type || !sts.in_valid) begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_INVALID;
						end else begin
							cmd.ent_sel = ENT_IN;
							phase_d     = PH_WALK;
							state_d     = S_LOC;
						end
					end
					ACT_TRUNCATE: begin
						if (sts.bad_type) begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_INVALID;
						end else if (sts.in_valid) begin
							cmd.ent_sel = ENT_IN;
							state_d     = S_LOC;
						end
					end
					default: ;
				endcase
			end
			S_BYTE_WAIT: begin
				cmd.rb_load = 1'b1;
				state_d     = S_DONE;
			end
			S_LOC: begin
				if (sts.loc_st != ST_OK) begin
					cmd.st_we     = 1'b1;
					cmd.st_val    = sts.loc_st;
					cmd.tail_load = (sts.act == ACT_APPEND) && (phase_q == PH_WALK);
					state_d       = S_DONE;
				end else begin
					cmd.bi_clr = 1'b1;
					state_d    = S_RD;
				end
			end
			S_RD: begin
				cmd.mem_re = 1'b1;
				if (sts.bi_last) begin
					state_d = S_RDW;
				end
			end
			S_RDW: begin
				state_d = S_USE;
			end
			S_USE: begin
				state_d = S_DONE;
				case (sts.act)
					ACT_GET_LINK: begin
						cmd.res_sel = RES_LINK;
					end
					ACT_SET_LINK, ACT_SET_LAST, ACT_TRUNCATE: begin
						cmd.bi_clr = 1'b1;
						state_d    = S_WR;
					end
					ACT_NTH: begin
						cmd.res_sel = RES_LINK;
						cmd.ent_sel = ENT_LINK;
						cmd.cnt_inc = 1'b1;
						if (!sts.link_valid) begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_INVALID;
						end else begin
							state_d = S_NTH_CHK;
						end
					end
					ACT_ALLOC_FIRST: begin
						if (sts.link_zero) begin
							cmd.bi_clr = 1'b1;
							state_d    = S_WR;
						end else if (!sts.scan_last) begin
							cmd.scan_sel = SCAN_NEXT;
							state_d      = S_PROBE;
						end
					end
					ACT_APPEND: begin
						case (phase_q)
							PH_WALK: begin
								if (sts.link_valid) begin
									if (sts.cnt_at_bound) begin
										cmd.st_we     = 1'b1;
										cmd.st_val    = ST_INVALID;
										cmd.tail_load = 1'b1;
									end else begin
										cmd.ent_sel = ENT_LINK;
										cmd.cnt_inc = 1'b1;
										state_d     = S_LOC;
									end
								end else begin
									// Tail found: start the search one past it.
									cmd.tail_load = 1'b1;
									cmd.st_we     = 1'b1;
									cmd.st_val    = ST_FULL;
									cmd.scan_sel  = SCAN_AFTER_ENT;
									phase_d       = PH_SEARCH;
									state_d       = S_SCHK;
								end
							end
							PH_SEARCH: begin
								if (sts.link_zero) begin
									cmd.bi_clr = 1'b1;
									state_d    = S_WR;
								end else begin
									cmd.scan_sel = SCAN_NEXT;
									state_d      = S_SCHK;
								end
							end
							default: begin
								cmd.bi_clr = 1'b1;
								state_d    = S_WR;
							end
						endcase
					end
					default: ;
				endcase
			end
			S_WR: begin
				cmd.mem_we = 1'b1;
				case (sts.act)
					ACT_SET_LINK: cmd.wval_sel = WV_LINKV;
					ACT_TRUNCATE: cmd.wval_sel = WV_ZERO;
					ACT_APPEND:   cmd.wval_sel = (phase_q == PH_TAIL) ? WV_SCAN : WV_END;
					default:      cmd.wval_sel = WV_END;
				endcase
				if (sts.bi_last) begin
					state_d = S_DONE;
					case (sts.act)
						ACT_ALLOC_FIRST: begin
							cmd.res_sel = RES_SCAN;
							cmd.st_we   = 1'b1;
							cmd.st_val  = ST_OK;
						end
						ACT_APPEND: begin
							if (phase_q == PH_TAIL) begin
								cmd.res_sel = RES_SCAN;
								cmd.st_we   = 1'b1;
								cmd.st_val  = ST_OK;
							end else begin
								// New cluster marked; now link the tail to it.
								phase_d     = PH_TAIL;
								cmd.ent_sel = ENT_TAIL;
								state_d     = S_LOC;
							end
						end
						ACT_TRUNCATE: begin
							cmd.ent_sel = ENT_LINK;
							if (sts.link_valid) begin
								state_d = S_LOC;
							end
						end
						default: ;
					endcase
				end
			end
			S_NTH_CHK: begin
				if (sts.walk_more) begin
					state_d = S_LOC;
				end else begin
					cmd.st_we  = sts.steps_over;
					cmd.st_val = ST_INVALID;
					state_d    = S_DONE;
				end
			end
			S_PROBE: begin
				cmd.ent_sel = ENT_SCAN;
				state_d     = S_LOC;
			end
			S_SCHK: begin
				state_d = sts.scan_is_tail ? S_DONE : S_PROBE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_WALK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

[rtl/core/fat_cluster_chain_engine_core.sv]
// FAT cluster chain engine.
// The items channel takes one action per request; the results channel returns
// exactly one answer per request, in order. The cfg channel writes the format,
// reserved bounds, end marker and table size; it is always ready, and the
// user must see that it is used only while no request is in flight; the
// block itself does not enforce this. The table is filled by load-byte
// requests. A request is captured in S_IDLE and dispatched in the next cycle.
// A load request writes its byte at dispatch; a read request reads at
// dispatch and captures the registered read data in S_BYTE_WAIT.
// An entry access checks the location in S_LOC, then in S_RD reads one byte
// per cycle through the single port of the table memory (two bytes for FAT12
// and FAT16, four for FAT32), waits for the registered read data in S_RDW and
// checks the entry in S_USE; a write goes through S_WR byte by byte.
// A new request is taken as soon as the previous answer sits in the output
// register, even if the receiver has not yet taken it; the engine only waits
// when a finished answer finds that register still full.
// Reset clears the controller and restores the configuration reset values;
// the table contents are undefined until loaded.
module fat_cluster_chain_engine_core #(
	parameter int FAT_BYTES = 65536
) (
	input logic          clk,
	input logic          arst_n,
	fcce_item_if.sink    items,
	fcce_result_if.source results,
	fcce_cfg_if.sink     cfg
);
	import fcce_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	// Sequencer.
	fcce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Table store, registers and arithmetic.
	fcce_dp #(
		.FAT_BYTES (FAT_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg.valid && cfg.ready),
		.cfg_idx         (cfg.index),
		.cfg_data        (cfg.data),
		.action          (items.action),
		.cluster         (items.cluster),
		.link_value      (items.link_value),
		.step_count      (items.step_count),
		.byte_address    (items.byte_address),
		.byte_value      (items.byte_value),
		.cmd             (cmd),
		.sts             (sts),
		.status          (results.status),
		.result_cluster  (results.result_cluster),
		.chain_tail      (results.chain_tail),
		.read_byte_value (results.read_byte_value)
	);

	// Only one request is in flight at a time.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready |=> !items.ready)
		else $error("request taken while another is in flight");

	// The table port never reads and writes in the same cycle.
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mem_we && cmd.mem_re))
		else $error("table read and write in the same cycle");

	// A loaded answer is offered in the next cycle.
	a_answer_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> results.valid)
		else $error("loaded answer not offered");

endmodule
